// ===== hdl/c2s_pkg.sv =====
// Shared constants, payload types and the arctangent table of the spherical binner.
`timescale 1ns / 1ps
`default_nettype none
package c2s_pkg;

   localparam int COORD_BITS   = 16;
   localparam int INDEX_BITS   = 20;
   localparam int STEP_W       = 15;
   localparam int RANGE_W      = 16;
   localparam int TILT_W       = 16;
   localparam int PAN_W        = 17;

   // CORDIC datapath: coordinates are scaled by 2^14 and need headroom for the gain.
   localparam int SCALE_SHIFT  = 14;
   localparam int CW           = COORD_BITS + SCALE_SHIFT + 4;
   localparam int ACC_W        = 26;
   localparam int CORDIC_STEPS = 16;
   localparam int ANG_SHIFT    = 8;

   // Square root of the sum of squares, one result bit per stage.
   localparam int SUM_W        = 2 * COORD_BITS;
   localparam int ROOT_W       = COORD_BITS;
   localparam int REM_W        = ROOT_W + 2;

   // Bin divider: dividend is twice the angle plus the step.
   localparam int DIV_N_W      = 18;
   localparam int DIV_D_W      = STEP_W + 1;

   localparam logic signed [15:0]      GAIN_Q14 = 16'sd26981;
   localparam logic signed [ACC_W-1:0] DEG_90   = ACC_W'(90 * 65536);
   localparam logic signed [ACC_W-1:0] DEG_180  = ACC_W'(180 * 65536);
   localparam logic signed [ACC_W-1:0] DEG_360  = ACC_W'(360 * 65536);
   localparam logic signed [ACC_W-1:0] ANG_HALF = ACC_W'(128);

   localparam logic [PAN_W-1:0]  PAN_FULL   = PAN_W'(92160);
   localparam logic [TILT_W-1:0] TILT_TOP   = TILT_W'(46080);
   localparam logic [TILT_W-1:0] TILT_MID   = TILT_W'(23040);
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

   typedef enum logic [0:0] {
      CSR_PAN_STEP  = 1'b0,
      CSR_TILT_STEP = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic [INDEX_BITS-1:0]        point_number;
   } req_payload_type;

   typedef struct packed {
      logic [RANGE_W-1:0]    range_mm;
      logic [TILT_W-1:0]     tilt_angle;
      logic [PAN_W-1:0]      pan_angle;
      logic [PAN_W-1:0]      pan_bin;
      logic [TILT_W-1:0]     tilt_bin;
      logic [INDEX_BITS-1:0] point_tag;
   } rsp_payload_type;

   // Rotation angle of CORDIC step i in 1/65536 degree.
   function automatic logic signed [ACC_W-1:0] atan_of(input int step);
      logic signed [ACC_W-1:0] ang;
      unique case (step)
         0:       ang = ACC_W'(2949120);
         1:       ang = ACC_W'(1740967);
         2:       ang = ACC_W'(919879);
         3:       ang = ACC_W'(466945);
         4:       ang = ACC_W'(234379);
         5:       ang = ACC_W'(117304);
         6:       ang = ACC_W'(58666);
         7:       ang = ACC_W'(29335);
         8:       ang = ACC_W'(14668);
         9:       ang = ACC_W'(7334);
         10:      ang = ACC_W'(3667);
         11:      ang = ACC_W'(1833);
         12:      ang = ACC_W'(917);
         13:      ang = ACC_W'(458);
         14:      ang = ACC_W'(229);
         15:      ang = ACC_W'(115);
         default: ang = '0;
      endcase
      return ang;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/c2s_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps
`default_nettype none
module c2s_cordic (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [c2s_pkg::CW-1:0]     start_x,
   input  logic signed [c2s_pkg::CW-1:0]     start_y,
   input  logic signed [c2s_pkg::ACC_W-1:0]  start_acc,
   output logic signed [c2s_pkg::CW-1:0]     final_x,
   output logic signed [c2s_pkg::ACC_W-1:0]  final_acc
);
   import c2s_pkg::*;

   logic signed [CW-1:0]    x_ff   [CORDIC_STEPS];
   logic signed [CW-1:0]    y_ff   [CORDIC_STEPS-1];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0]    x_cur, y_cur, x_in, y_in;
      logic signed [ACC_W-1:0] a_cur, a_in;

      if (i == 0) begin : g_first
         assign x_cur = start_x;
         assign y_cur = start_y;
         assign a_cur = start_acc;
      end else begin : g_next
         assign x_cur = x_ff[i-1];
         assign y_cur = y_ff[i-1];
         assign a_cur = acc_ff[i-1];
      end

      // Rotate toward the x axis; the sign of y picks the direction.
      always_comb begin
         if (!y_cur[CW-1]) begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            a_in = a_cur + atan_of(i);
         end else begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            a_in = a_cur - atan_of(i);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]   <= x_in;
            acc_ff[i] <= a_in;
         end
      end

      if (i < CORDIC_STEPS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               y_ff[i] <= y_in;
            end
         end
      end
   end

   assign final_x   = x_ff[CORDIC_STEPS-1];
   assign final_acc = acc_ff[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/c2s_divider.sv =====
// Pipelined restoring divider for the grid bins, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module c2s_divider (
   input  logic                           clock,
   input  logic                           advance,
   input  logic [c2s_pkg::DIV_N_W-1:0]    dividend,
   input  logic [c2s_pkg::DIV_D_W-1:0]    divisor,
   output logic [c2s_pkg::DIV_N_W-1:0]    quotient
);
   import c2s_pkg::*;

   // Dividend bits leave at the top while quotient bits enter at the bottom.
   logic [DIV_N_W-1:0] nq_ff   [DIV_N_W];
   logic [DIV_D_W-1:0] part_ff [DIV_N_W-1];
   logic [DIV_D_W-1:0] den_ff  [DIV_N_W-1];

   for (genvar i = 0; i < DIV_N_W; i++) begin : g_step
      logic [DIV_N_W-1:0] nq_cur, nq_in;
      logic [DIV_D_W-1:0] part_cur, den_cur;
      logic [DIV_D_W:0]   trial, diff;

      if (i == 0) begin : g_first
         assign nq_cur   = dividend;
         assign part_cur = '0;
         assign den_cur  = divisor;
      end else begin : g_next
         assign nq_cur   = nq_ff[i-1];
         assign part_cur = part_ff[i-1];
         assign den_cur  = den_ff[i-1];
      end

      always_comb begin
         trial = {part_cur, nq_cur[DIV_N_W-1]};
         diff  = trial - {1'b0, den_cur};
         nq_in = {nq_cur[DIV_N_W-2:0], ~diff[DIV_D_W]};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            nq_ff[i] <= nq_in;
         end
      end

      if (i < DIV_N_W - 1) begin : g_carry
         logic [DIV_D_W-1:0] part_in;

         assign part_in = diff[DIV_D_W] ? trial[DIV_D_W-1:0] : diff[DIV_D_W-1:0];

         always_ff @(posedge clock) begin
            if (advance) begin
               part_ff[i] <= part_in;
               den_ff[i]  <= den_cur;
            end
         end
      end
   end

   assign quotient = nq_ff[DIV_N_W-1];

endmodule
`default_nettype wire

// ===== hdl/cartesian_to_spherical_binner.sv =====
// Top level: point to range, tilt, pan and grid bins, fully pipelined.
//
//   port group   direction   handshake              carries
//   req_*        in          req_valid/req_ready    coordinates and point number
//   rsp_*        out         rsp_valid/rsp_ready    range, angles, bins, point tag
//   csr_*        in          csr_write              pan_step, tilt_step
//
// One point enters per cycle unless the output register is held; the pipeline is 53
// registers deep. The depth is set by the input register, one setup stage, two
// chained 16-stage CORDIC units, one finishing stage and an 18-stage bin divider;
// the square root runs beside the first CORDIC.
// Reset clears the valid bits and sets both steps to 256.
// When the output register is held, the whole pipeline holds with it.
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_spherical_binner (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  c2s_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output c2s_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_write,
   input  c2s_pkg::csr_index_type           csr_index,
   input  logic [c2s_pkg::STEP_W-1:0]       csr_wdata
);
   import c2s_pkg::*;

   localparam int PAN_END  = 2 + CORDIC_STEPS;
   localparam int TILT_END = PAN_END + CORDIC_STEPS;
   localparam int FIN      = TILT_END + 1;
   localparam int LAT      = FIN + DIV_N_W;
   localparam int SQ_END   = 3 + ROOT_W;
   localparam int RND      = SQ_END + 1;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   point_tag;
      logic signed [CW-1:0]    z_gain;
      logic                    on_axis;
      logic                    z_pos;
      logic                    z_neg;
      logic signed [ACC_W-1:0] pan_acc;
      logic [RANGE_W-1:0]      range_mm;
      logic [PAN_W-1:0]        pan_angle;
      logic [TILT_W-1:0]       tilt_angle;
   } side_type;

   logic                 advance;
   logic                 valid_ff [1:LAT];
   side_type             side_ff  [1:LAT];
   side_type             side_in  [1:LAT];
   logic [STEP_W-1:0]    pan_step_ff, tilt_step_ff;

   assign advance   = !valid_ff[LAT] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_step_ff  <= STEP_RESET;
         tilt_step_ff <= STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PAN_STEP:  pan_step_ff  <= csr_wdata;
            CSR_TILT_STEP: tilt_step_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= LAT; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[1] <= req_valid;
         for (int s = 2; s <= LAT; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   // Stage 1: input register.
   req_payload_type in_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_data;
      end
   end

   // Stage 2: squares, CORDIC start values and the gain-scaled z.
   logic signed [SUM_W-1:0]        sqx_prod, sqy_prod, sqz_prod;
   logic signed [COORD_BITS+15:0]  zg_prod;
   logic signed [CW-1:0]           xw, yw, px_in, py_in, zg_in;
   logic signed [ACC_W-1:0]        pa_in;
   logic [SUM_W-1:0]               sqx_ff, sqy_ff, sqz_ff, sum_ff;
   logic signed [CW-1:0]           px_ff, py_ff;
   logic signed [ACC_W-1:0]        pa_ff;

   always_comb begin
      sqx_prod = in_ff.pos_x * in_ff.pos_x;
      sqy_prod = in_ff.pos_y * in_ff.pos_y;
      sqz_prod = in_ff.pos_z * in_ff.pos_z;
      zg_prod  = in_ff.pos_z * GAIN_Q14;
      zg_in    = CW'(zg_prod);
      xw       = CW'(in_ff.pos_x) <<< SCALE_SHIFT;
      yw       = CW'(in_ff.pos_y) <<< SCALE_SHIFT;
      // Left half plane: mirror the point and start from 180 degrees.
      if (in_ff.pos_x[COORD_BITS-1]) begin
         px_in = -xw;
         py_in = -yw;
         pa_in = DEG_180;
      end else begin
         px_in = xw;
         py_in = yw;
         pa_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff <= unsigned'(sqx_prod);
         sqy_ff <= unsigned'(sqy_prod);
         sqz_ff <= unsigned'(sqz_prod);
         px_ff  <= px_in;
         py_ff  <= py_in;
         pa_ff  <= pa_in;
         sum_ff <= sqx_ff + sqy_ff + sqz_ff;
      end
   end

   // Square root, two radicand bits per stage.
   logic [SUM_W-1:0]  rad_ff  [ROOT_W-1];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      logic [SUM_W-1:0]   rad_cur;
      logic [REM_W-1:0]   rem_cur, rem_in;
      logic [ROOT_W-1:0]  root_cur, root_in;
      logic [REM_W+1:0]   rem_shift, trial;

      if (i == 0) begin : g_first
         assign rad_cur  = sum_ff;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
      end

      always_comb begin
         rem_shift = {rem_cur, rad_cur[SUM_W-1:SUM_W-2]};
         trial     = (REM_W+2)'({root_cur, 2'b01});
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_cur[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
         end
      end

      if (i < ROOT_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rad_ff[i] <= rad_cur << 2;
            end
         end
      end
   end

   // Round to nearest: bump the root when the remainder exceeds it.
   logic [ROOT_W:0]    root_rnd;
   logic [RANGE_W-1:0] range_rnd;

   always_comb begin
      root_rnd  = {1'b0, root_ff[ROOT_W-1]}
                  + (ROOT_W+1)'(rem_ff[ROOT_W-1] > REM_W'(root_ff[ROOT_W-1]));
      range_rnd = RANGE_W'(root_rnd);
   end

   // Pan and tilt CORDIC units.
   logic signed [CW-1:0]    pan_x, tilt_x;
   logic signed [ACC_W-1:0] pan_acc, tilt_acc;

   c2s_cordic u_pan (
      .clock     (clock),
      .advance   (advance),
      .start_x   (px_ff),
      .start_y   (py_ff),
      .start_acc (pa_ff),
      .final_x   (pan_x),
      .final_acc (pan_acc)
   );

   c2s_cordic u_tilt (
      .clock     (clock),
      .advance   (advance),
      .start_x   (pan_x),
      .start_y   (side_ff[PAN_END].z_gain),
      .start_acc ('0),
      .final_x   (tilt_x),
      .final_acc (tilt_acc)
   );

   // Finishing stage: wrap, offset, clamp and round both angles.
   logic signed [ACC_W-1:0] pan_wrap, pan_sum, tilt_off, tilt_clamp, tilt_sum;
   logic [PAN_W-1:0]        pan_q, pan_fin;
   logic [TILT_W-1:0]       tilt_fin;

   always_comb begin
      pan_wrap = side_ff[TILT_END].pan_acc;
      if (pan_wrap[ACC_W-1]) pan_wrap = pan_wrap + DEG_360;
      pan_sum  = pan_wrap + ANG_HALF;
      pan_q    = PAN_W'(pan_sum >>> ANG_SHIFT);
      if (pan_q >= PAN_FULL) pan_q = pan_q - PAN_FULL;

      tilt_off   = tilt_acc + DEG_90;
      tilt_clamp = tilt_off;
      if (tilt_off[ACC_W-1]) tilt_clamp = '0;
      else if (tilt_off > DEG_180) tilt_clamp = DEG_180;
      tilt_sum = tilt_clamp + ANG_HALF;

      // A point on the z axis has no pan; its tilt follows the sign of z.
      if (side_ff[TILT_END].on_axis) begin
         pan_fin = '0;
         if (side_ff[TILT_END].z_pos) tilt_fin = TILT_TOP;
         else if (side_ff[TILT_END].z_neg) tilt_fin = '0;
         else tilt_fin = TILT_MID;
      end else begin
         pan_fin  = pan_q;
         tilt_fin = TILT_W'(tilt_sum >>> ANG_SHIFT);
      end
   end

   // Sideband pipeline: each field is loaded at its stage and carried along.
   always_comb begin
      side_in[1]           = '0;
      side_in[1].point_tag = req_data.point_number;
      for (int s = 2; s <= LAT; s++) begin
         side_in[s] = side_ff[s-1];
         if (s == 2) begin
            side_in[s].z_gain  = zg_in;
            side_in[s].on_axis = (in_ff.pos_x == '0) && (in_ff.pos_y == '0);
            side_in[s].z_pos   = !in_ff.pos_z[COORD_BITS-1] && (in_ff.pos_z != '0);
            side_in[s].z_neg   = in_ff.pos_z[COORD_BITS-1];
         end
         if (s == PAN_END + 1) side_in[s].pan_acc = pan_acc;
         if (s == RND) side_in[s].range_mm = range_rnd;
         if (s == FIN) begin
            side_in[s].pan_angle  = pan_fin;
            side_in[s].tilt_angle = tilt_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 1; s <= LAT; s++) side_ff[s] <= side_in[s];
      end
   end

   // Bins: (2 * angle + step) / (2 * step), a zero step counting as one.
   logic [STEP_W-1:0]  pan_eff, tilt_eff;
   logic [DIV_N_W-1:0] pan_num, tilt_num, pan_quo, tilt_quo;

   always_comb begin
      pan_eff  = (pan_step_ff == '0) ? STEP_W'(1) : pan_step_ff;
      tilt_eff = (tilt_step_ff == '0) ? STEP_W'(1) : tilt_step_ff;
      pan_num  = DIV_N_W'({side_ff[FIN].pan_angle, 1'b0}) + DIV_N_W'(pan_step_ff);
      tilt_num = DIV_N_W'({side_ff[FIN].tilt_angle, 1'b0}) + DIV_N_W'(tilt_step_ff);
      if (pan_step_ff == '0) pan_num = pan_num + DIV_N_W'(1);
      if (tilt_step_ff == '0) tilt_num = tilt_num + DIV_N_W'(1);
   end

   c2s_divider u_pan_bin (
      .clock    (clock),
      .advance  (advance),
      .dividend (pan_num),
      .divisor  ({pan_eff, 1'b0}),
      .quotient (pan_quo)
   );

   c2s_divider u_tilt_bin (
      .clock    (clock),
      .advance  (advance),
      .dividend (tilt_num),
      .divisor  ({tilt_eff, 1'b0}),
      .quotient (tilt_quo)
   );

   always_comb begin
      rsp_data.range_mm   = side_ff[LAT].range_mm;
      rsp_data.tilt_angle = side_ff[LAT].tilt_angle;
      rsp_data.pan_angle  = side_ff[LAT].pan_angle;
      rsp_data.pan_bin    = PAN_W'(pan_quo);
      rsp_data.tilt_bin   = TILT_W'(tilt_quo);
      rsp_data.point_tag  = side_ff[LAT].point_tag;
   end

   logic unused_x;
   assign unused_x = ^tilt_x;

endmodule
`default_nettype wire

// ===== hdl/c2s_checker.sv =====
// Port-level assertions for the spherical binner and their bind.
`timescale 1ns / 1ps
`default_nettype none
module c2s_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  c2s_pkg::req_payload_type    req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  c2s_pkg::rsp_payload_type    rsp_data,
   input  logic                        csr_write,
   input  c2s_pkg::csr_index_type      csr_index,
   input  logic [c2s_pkg::STEP_W-1:0]  csr_wdata
);
   import c2s_pkg::*;

   // A held result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // With an empty output register the pipeline must take new points.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending result");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pan_angle < PAN_FULL) && (rsp_data.tilt_angle <= TILT_TOP))
      else $error("angle out of range");

   // Only the origin has zero range, and it maps to the horizon with no pan.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.range_mm == '0) |->
         (rsp_data.tilt_angle == TILT_MID) && (rsp_data.pan_angle == '0))
      else $error("zero-range point has wrong angles");

   logic unused_in;
   assign unused_in = req_valid ^ (^req_data) ^ csr_write ^ (^csr_index) ^ (^csr_wdata);

endmodule

bind cartesian_to_spherical_binner c2s_checker u_c2s_checker (.*);
`default_nettype wire

// ===== test/c2s_checker.sv =====
// Checker for the spherical binner: predicts each result and compares it with the block.
`timescale 1ns / 1ps
`default_nettype none
module c2s_scoreboard (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  c2s_pkg::req_payload_type   req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  c2s_pkg::rsp_payload_type   rsp_data,
   input  logic                       csr_write,
   input  c2s_pkg::csr_index_type     csr_index,
   input  logic [c2s_pkg::STEP_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending_count
);
   import c2s_pkg::*;

   localparam longint ANGLE_ONE = 65536;
   localparam longint GAIN = 26981;

   longint rot_table [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

   logic [STEP_W-1:0] pan_step_q, tilt_step_q;
   rsp_payload_type   expected_points [$];

   assign pending_count = expected_points.size();

   // Floor shift of a signed value.
   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   // Vectoring rotation: drives b to zero and returns the accumulated angle.
   function automatic longint rotate_to_axis(inout longint a, input longint b,
                                             input longint angle);
      longint da, db;
      for (int i = 0; i < 16; i++) begin
         da = floor_shift(b, i);
         db = floor_shift(a, i);
         if (b >= 0) begin
            a += da; b -= db; angle += rot_table[i];
         end else begin
            a -= da; b += db; angle -= rot_table[i];
         end
      end
      return angle;
   endfunction

   function automatic longint grid_bin(longint angle, longint step);
      if (step == 0) step = 1;
      return (2 * angle + step) / (2 * step);
   endfunction

   function automatic rsp_payload_type spherical_of(req_payload_type p);
      rsp_payload_type res;
      longint x, y, z, sq, root, pan, tilt, xs, ys, acc, t;
      x = p.pos_x; y = p.pos_y; z = p.pos_z;
      sq = x * x + y * y + z * z;
      root = longint'($floor($sqrt(real'(sq))));
      while (root * root > sq) root--;
      while ((root + 1) * (root + 1) <= sq) root++;
      if (sq - root * root > root) root++;
      if (x == 0 && y == 0) begin
         pan = 0;
         tilt = z > 0 ? 46080 : (z < 0 ? 0 : 23040);
      end else begin
         xs = x * 16384; ys = y * 16384; acc = 0;
         if (xs < 0) begin
            xs = -xs; ys = -ys; acc = 180 * ANGLE_ONE;
         end
         acc = rotate_to_axis(xs, ys, acc);
         if (acc < 0) acc += 360 * ANGLE_ONE;
         pan = (acc + 128) >>> 8;
         if (pan >= 92160) pan -= 92160;
         t = rotate_to_axis(xs, z * GAIN, 0) + 90 * ANGLE_ONE;
         if (t < 0) t = 0;
         if (t > 180 * ANGLE_ONE) t = 180 * ANGLE_ONE;
         tilt = (t + 128) >>> 8;
      end
      res.range_mm = root[15:0];
      res.tilt_angle = tilt[15:0];
      res.pan_angle = pan[16:0];
      res.pan_bin = 17'(grid_bin(pan, pan_step_q));
      res.tilt_bin = 16'(grid_bin(tilt, tilt_step_q));
      res.point_tag = p.point_number;
      return res;
   endfunction

   always_ff @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         pan_step_q <= STEP_RESET;
         tilt_step_q <= STEP_RESET;
         expected_points.delete();
         fail_count <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_PAN_STEP) pan_step_q <= csr_wdata;
            else tilt_step_q <= csr_wdata;
         end
         if (req_valid && req_ready)
            expected_points.insert(expected_points.size(), spherical_of(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_points.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench top: drives points and step registers into the spherical binner.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import c2s_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_write = 1'b0;
   csr_index_type csr_index = CSR_PAN_STEP;
   logic [STEP_W-1:0] csr_wdata = '0;
   int fail_count, pending_count;
   bit quiet_phase = 1'b0;
   int hold_off = 0;

   cartesian_to_spherical_binner dut (.*);

   c2s_scoreboard checker_inst (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_write, .csr_index, .csr_wdata, .fail_count, .pending_count
   );

   initial forever #10 clock = ~clock;

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stalls, one long hold-off requested by the stimulus.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= quiet_phase || ($urandom_range(99) >= 12);
      end
   end

   function automatic logic signed [15:0] pick_coord();
      unique case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3: return 16'($signed(12'($urandom)));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
      req_payload_type p;
      p.pos_x = x; p.pos_y = y; p.pos_z = z;
      p.point_number = 20'($urandom);
      while (!quiet_phase && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_steps(logic [STEP_W-1:0] pan, logic [STEP_W-1:0] tilt);
      csr_write <= 1'b1; csr_index <= CSR_PAN_STEP; csr_wdata <= pan;
      @(posedge clock);
      csr_index <= CSR_TILT_STEP; csr_wdata <= tilt;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [STEP_W-1:0] steps [6] = '{15'd256, 15'd1, 15'd23040, 15'd0, 15'd32767, 15'd90};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed corners: origin, axes, extremes, pan wrap near 360 degrees.
      send_point(16'sd0, 16'sd0, 16'sd0);
      send_point(16'sd0, 16'sd0, 16'sd100);
      send_point(16'sd0, 16'sd0, -16'sd100);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh8000, 16'sd0, 16'sd0);
      send_point(16'sd0, 16'sh8000, 16'sd0);
      send_point(16'sd0, 16'sh7fff, 16'sh8000);
      send_point(-16'sd1, 16'sd0, 16'sd0);
      send_point(16'sd1, 16'sd0, 16'sd0);
      send_point(16'sd30000, -16'sd1, 16'sd0);
      send_point(-16'sd5, 16'sd5, 16'sd3);
      send_point(16'sh7fff, -16'sh7fff, 16'sd1);
      for (int phase = 0; phase < 6; phase++) begin
         drain_block();
         write_steps(steps[phase], steps[(phase + 3) % 6]);
         quiet_phase = (phase == 2);
         if (phase == 4) hold_off <= 400;
         for (int i = 0; i < 190; i++) send_point(pick_coord(), pick_coord(), pick_coord());
         quiet_phase = 1'b0;
      end
      drain_block();
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire
